@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked only out of reset.
`define TDSS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked at every edge, reset included.
`define TDSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TDSS_ASSERT(lbl, clk, rst_n, prop, msg)
`define TDSS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/tdss_pkg.sv @@
// Types, constants and the segment decoder of the seven-segment scan driver.
package tdss_pkg;

    localparam int NUM_W   = 32;
    localparam int DIGIT_W = 4;
    localparam int POS_W   = 2;
    localparam int SEG_W   = 7;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Scan positions
    localparam logic [POS_W-1:0] POS_ONES     = 2'd0;
    localparam logic [POS_W-1:0] POS_TENS     = 2'd1;
    localparam logic [POS_W-1:0] POS_HUNDREDS = 2'd2;

    // n / 1000 == (n * RECIP_1000) >> RECIP_SHIFT for every 32-bit n
    localparam int RECIP_W     = 29;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam int RECIP_SHIFT = 38;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;

    // Remainder mod 1000 fits in 10 bits
    localparam int REM_W = 10;
    // r / 10 == (r * 205) >> 11 for r < 1024
    localparam int P2_W = 18;
    // t / 10 == (t * 103) >> 10 for t < 100
    localparam int T_W  = 7;
    localparam int P3_W = 14;

    // Item from the front to the back
    typedef struct packed {
        logic             tick;
        logic [NUM_W-1:0] number;
    } t_item;

    // Segment pattern, bit 0 = A .. bit 6 = G; non-decimal codes stay dark
    function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] seg;
        unique case (digit)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

@@ rtl/three_digit_seven_segment_scan.sv @@
// Top level of the multiplexed three-digit seven-segment scan driver.
// Input words carry a command in s_axis_tuser (load or tick) and a 32-bit number in
// s_axis_tdata; a load stores the ones, tens and hundreds digits of the number (the
// number mod 1000) and gives no result, a tick gives one result word with the active
// digit index (0 ones, 1 tens, 2 hundreds) and its segment pattern (bit 0 A .. bit 6 G),
// then steps the scan. The block takes one word per clock sustained while the receiver
// keeps m_axis_tready high; a tick passes through the two-entry input queue and the
// four-stage digit extraction pipeline (reciprocal multiply by 1/1000, then two
// divide-by-ten steps) ahead of the output register. Ticks flow through the same
// pipeline, so they always show the digits of every load accepted before them.
module three_digit_seven_segment_scan (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] number_value
    input  logic        s_axis_tuser,   // [0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] segments, [7] zero
    output logic [1:0]  m_axis_tuser    // [1:0] digit_index
);

    logic            w_head_valid;
    tdss_pkg::t_item w_head;
    logic            w_pop;

    tdss_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_head_valid  (w_head_valid),
        .o_head        (w_head),
        .i_pop         (w_pop)
    );

    tdss_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (w_head_valid),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

@@ rtl/tdss_front.sv @@
// Front end: accepts input words, classifies them and queues them for the back end.
module tdss_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [tdss_pkg::NUM_W-1:0] s_axis_tdata,
    input  logic                     s_axis_tuser,
    output logic                     o_head_valid,
    output tdss_pkg::t_item          o_head,
    input  logic                     i_pop
);

    logic            r_wr;
    logic            r_rd;
    logic [1:0]      r_count;
    logic [1:0]      n_count;
    tdss_pkg::t_item r_slot [2];
    tdss_pkg::t_item w_item;
    logic            w_push;
    logic            w_pop;

    // Classify the incoming word
    always_comb begin
        w_item.tick   = (s_axis_tuser == tdss_pkg::CMD_TICK);
        w_item.number = s_axis_tdata;
    end

    assign s_axis_tready = (r_count != 2'd2);
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign w_pop         = i_pop && (r_count != 2'd0);
    assign o_head_valid  = (r_count != 2'd0);
    assign o_head        = r_slot[r_rd];

    // Occupancy
    always_comb begin
        n_count = r_count;
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    // Queue slots, no reset
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= w_item;
        end
    end

endmodule

@@ rtl/tdss_back.sv @@
// Back end: digit extraction pipeline, digit store, scan counter and output register.
`include "assert_macros.svh"

module tdss_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_head_valid,
    input  tdss_pkg::t_item            i_head,
    output logic                       o_pop,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [7:0]                 m_axis_tdata,
    output logic [tdss_pkg::POS_W-1:0] m_axis_tuser
);

    logic w_en;

    // Stage valid and kind bits
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic r_s1_tick,  r_s2_tick,  r_s3_tick,  r_s4_tick;

    // Stage payload
    logic [tdss_pkg::PROD_W-1:0] w_prod;
    logic [tdss_pkg::REM_W-1:0]  r_s1_q;
    logic [tdss_pkg::REM_W-1:0]  r_s1_n;
    logic [tdss_pkg::REM_W-1:0]  r_s2_r;
    logic [tdss_pkg::REM_W-1:0]  r_s3_r;
    logic [tdss_pkg::P2_W-1:0]   r_s3_p2;
    logic [tdss_pkg::T_W-1:0]    w_t;
    logic [tdss_pkg::REM_W-1:0]  w_ones_full;
    logic [tdss_pkg::T_W-1:0]    r_s4_t;
    logic [tdss_pkg::DIGIT_W-1:0] r_s4_ones;
    logic [tdss_pkg::P3_W-1:0]   r_s4_p3;
    logic [tdss_pkg::DIGIT_W-1:0] w_hund;
    logic [tdss_pkg::T_W-1:0]    w_tens_full;

    // Display state
    logic [tdss_pkg::DIGIT_W-1:0] r_ones, r_tens, r_hund;
    logic [tdss_pkg::POS_W-1:0]   r_scan_pos;
    logic [tdss_pkg::POS_W-1:0]   w_pos;
    logic [tdss_pkg::POS_W-1:0]   n_scan_pos;
    logic [tdss_pkg::DIGIT_W-1:0] w_digit;

    // Output register
    logic                         r_out_valid;
    logic [tdss_pkg::POS_W-1:0]   r_out_idx;
    logic [tdss_pkg::SEG_W-1:0]   r_out_seg;

    // Whole pipeline moves when the output register is free or being drained
    assign w_en  = !r_out_valid || m_axis_tready;
    assign o_pop = w_en && i_head_valid;

    // Stage 1 math: quotient by 1000 via reciprocal
    assign w_prod = tdss_pkg::PROD_W'(i_head.number) * tdss_pkg::PROD_W'(tdss_pkg::RECIP_1000);

    // Stage 4 math: tens quotient and ones digit
    assign w_t         = r_s3_p2[tdss_pkg::P2_W-1 -: tdss_pkg::T_W];
    assign w_ones_full = r_s3_r - tdss_pkg::REM_W'(w_t) * 10'd10;

    // Commit math: hundreds and tens digits
    assign w_hund      = r_s4_p3[tdss_pkg::P3_W-1 -: tdss_pkg::DIGIT_W];
    assign w_tens_full = r_s4_t - tdss_pkg::T_W'(w_hund) * 7'd10;

    // Scan position used by a tick and the next one
    always_comb begin
        w_pos = (r_scan_pos > tdss_pkg::POS_HUNDREDS) ? tdss_pkg::POS_ONES : r_scan_pos;
        n_scan_pos = (w_pos == tdss_pkg::POS_HUNDREDS) ? tdss_pkg::POS_ONES
                                                       : w_pos + 2'd1;
        unique case (w_pos)
            tdss_pkg::POS_TENS:     w_digit = r_tens;
            tdss_pkg::POS_HUNDREDS: w_digit = r_hund;
            default:                w_digit = r_ones;
        endcase
    end

    // Control: stage valid bits, digits, scan, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ones      <= '0;
            r_tens      <= '0;
            r_hund      <= '0;
            r_scan_pos  <= tdss_pkg::POS_ONES;
        end else if (w_en) begin
            r_s1_valid  <= i_head_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_out_valid <= r_s4_valid && r_s4_tick;
            if (r_s4_valid && !r_s4_tick) begin
                r_ones <= r_s4_ones;
                r_tens <= w_tens_full[tdss_pkg::DIGIT_W-1:0];
                r_hund <= w_hund;
            end
            if (r_s4_valid && r_s4_tick) begin
                r_scan_pos <= n_scan_pos;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_tick <= i_head.tick;
            r_s1_q    <= w_prod[tdss_pkg::RECIP_SHIFT +: tdss_pkg::REM_W];
            r_s1_n    <= i_head.number[tdss_pkg::REM_W-1:0];
            r_s2_tick <= r_s1_tick;
            r_s2_r    <= r_s1_n - r_s1_q * 10'd1000;
            r_s3_tick <= r_s2_tick;
            r_s3_r    <= r_s2_r;
            r_s3_p2   <= tdss_pkg::P2_W'(r_s2_r) * 18'd205;
            r_s4_tick <= r_s3_tick;
            r_s4_t    <= w_t;
            r_s4_ones <= w_ones_full[tdss_pkg::DIGIT_W-1:0];
            r_s4_p3   <= tdss_pkg::P3_W'(w_t) * 14'd103;
            if (r_s4_valid && r_s4_tick) begin
                r_out_idx <= w_pos;
                r_out_seg <= tdss_pkg::seg_of(w_digit);
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_idx;
    assign m_axis_tdata  = {1'b0, r_out_seg};

    // Checks
    `TDSS_ASSERT(a_out_follows_tick, i_clk, i_rst_n,
        w_en |=> (r_out_valid == $past(r_s4_valid && r_s4_tick)), "output valid mismatch")
    `TDSS_ASSERT(a_load_decimal, i_clk, i_rst_n,
        (w_en && r_s4_valid && !r_s4_tick) |=> (r_ones <= 4'd9 && r_tens <= 4'd9 && r_hund <= 4'd9),
        "loaded digit not decimal")
    `TDSS_ASSERT(a_scan_advance, i_clk, i_rst_n,
        (w_en && r_s4_valid && r_s4_tick) |=> (r_scan_pos == $past(n_scan_pos)),
        "scan position did not advance")

endmodule

@@ tb/sv/three_digit_seven_segment_scan_checker.sv @@
// Checker for the seven-segment scan driver: predicts each tick's result word and compares.
module three_digit_seven_segment_scan_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] number_value
    input  logic        i_s_axis_tuser,   // [0] cmd
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [7:0]  i_m_axis_tdata,   // [6:0] segments, [7] zero
    input  logic [1:0]  i_m_axis_tuser,   // [1:0] digit_index
    output int          o_mismatches,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [tdss_pkg::POS_W-1:0] digit_index;
        logic [tdss_pkg::SEG_W-1:0] segments;
    } t_scan_word;

    // Shadow of the display state
    logic [tdss_pkg::DIGIT_W-1:0] ones_q;
    logic [tdss_pkg::DIGIT_W-1:0] tens_q;
    logic [tdss_pkg::DIGIT_W-1:0] hundreds_q;
    logic [tdss_pkg::POS_W-1:0]   scan_pos_q;

    t_scan_word shown_q[$];
    int         mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    // Segment lookup, A in bit 0; anything above nine stays dark
    function automatic logic [tdss_pkg::SEG_W-1:0] lit_segments(
        input logic [tdss_pkg::DIGIT_W-1:0] digit);
        logic [tdss_pkg::SEG_W-1:0] seg;
        case (digit)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = '0;
        endcase
        return seg;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < 40) begin
            $display("%0t ns: mismatch: %s", $realtime, what);
        end
        mismatch_count++;
    endtask

    // Load stores the low three decimal digits; tick drives one digit and steps the scan
    task automatic absorb_word(input logic cmd, input logic [tdss_pkg::NUM_W-1:0] number);
        logic [tdss_pkg::NUM_W-1:0]   quot;
        logic [tdss_pkg::POS_W-1:0]   pos;
        logic [tdss_pkg::DIGIT_W-1:0] digit;
        t_scan_word                   word;
        if (cmd == tdss_pkg::CMD_LOAD) begin
            quot       = number % 32'd10;
            ones_q     = quot[tdss_pkg::DIGIT_W-1:0];
            quot       = (number / 32'd10) % 32'd10;
            tens_q     = quot[tdss_pkg::DIGIT_W-1:0];
            quot       = (number / 32'd100) % 32'd10;
            hundreds_q = quot[tdss_pkg::DIGIT_W-1:0];
        end else begin
            pos = scan_pos_q;
            // the unused fourth position falls back to the ones digit
            if (pos > tdss_pkg::POS_HUNDREDS) begin
                pos = tdss_pkg::POS_ONES;
            end
            case (pos)
                tdss_pkg::POS_ONES: digit = ones_q;
                tdss_pkg::POS_TENS: digit = tens_q;
                default:            digit = hundreds_q;
            endcase
            word.digit_index = pos;
            word.segments    = lit_segments(digit);
            shown_q.push_back(word);
            scan_pos_q = (pos == tdss_pkg::POS_HUNDREDS) ? tdss_pkg::POS_ONES : pos + 1'b1;
        end
    endtask

    // Watch both channels at each edge
    always @(posedge i_clk) begin : monitor
        t_scan_word want;
        if (!i_rst_n) begin
            ones_q     = '0;
            tens_q     = '0;
            hundreds_q = '0;
            scan_pos_q = tdss_pkg::POS_ONES;
            shown_q.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                absorb_word(i_s_axis_tuser, i_s_axis_tdata);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (shown_q.size() == 0) begin
                    report_mismatch($sformatf("result word with nothing expected: idx %0d seg %02h",
                                              i_m_axis_tuser,
                                              i_m_axis_tdata[tdss_pkg::SEG_W-1:0]));
                end else begin
                    want = shown_q.pop_front();
                    if (i_m_axis_tuser != want.digit_index) begin
                        report_mismatch($sformatf("digit_index %0d, expected %0d",
                                                  i_m_axis_tuser, want.digit_index));
                    end
                    if (i_m_axis_tdata[tdss_pkg::SEG_W-1:0] != want.segments) begin
                        report_mismatch($sformatf("segments %02h, expected %02h (digit %0d)",
                                                  i_m_axis_tdata[tdss_pkg::SEG_W-1:0],
                                                  want.segments, want.digit_index));
                    end
                end
            end
        end
        o_pending <= shown_q.size();
    end

endmodule

@@ tb/sv/three_digit_seven_segment_scan_tb.sv @@
// Testbench top for the seven-segment scan driver: clock, reset, stimulus and verdict.
module three_digit_seven_segment_scan_tb;
    import tdss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORDS_PER_PHASE = 570;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int DRAIN_CYCLES    = 20;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;    // [31:0] number_value
    logic        s_axis_tuser  = CMD_LOAD; // [0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [6:0] segments, [7] zero
    logic [1:0]  m_axis_tuser;          // [1:0] digit_index

    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;
    int stall_cycles = 0;
    int mismatches;
    int pending;

    // 12 ns clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    three_digit_seven_segment_scan DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    three_digit_seven_segment_scan_checker scan_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    // Receiver backpressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Watchdog: cycles without any accepted word
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("three_digit_seven_segment_scan_tb NOT OK");
                $finish;
            end
        end
    end

    // One word, with random gaps ahead of it; returns at the accepting edge
    task automatic send_word(input logic cmd, input logic [31:0] number);
        while ($urandom_range(99) < tx_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= number;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_ticks(input int count);
        repeat (count) begin
            send_word(CMD_TICK, $urandom);
        end
    endtask

    // Mostly ticks so results stay frequent; numbers spread over all magnitudes
    task automatic send_random_words(input int count);
        logic [31:0] number;
        repeat (count) begin
            case ($urandom_range(3))
                0:       number = $urandom;
                1:       number = $urandom_range(999);
                2:       number = 32'hFFFF_FFFF - $urandom_range(999);
                default: number = $urandom >> $urandom_range(31);
            endcase
            send_word(($urandom_range(99) < 65) ? CMD_TICK : CMD_LOAD, number);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender idles lightly, receiver heavily
        tx_gap_pct    = 22;
        rx_stall_pct <= 52;

        // reset digits, full scan and wrap back to ones
        send_ticks(4);
        // zero, then the largest number (shows 295)
        send_word(CMD_LOAD, 32'd0);
        send_ticks(3);
        send_word(CMD_LOAD, 32'hFFFF_FFFF);
        send_ticks(3);
        // load in mid-scan keeps the scan position
        send_word(CMD_LOAD, 32'd987);
        send_ticks(1);
        send_word(CMD_LOAD, 32'd654);
        send_ticks(2);
        // back-to-back loads, the last one wins (1000 shows 000)
        send_word(CMD_LOAD, 32'd321);
        send_word(CMD_LOAD, 32'd1000);
        send_ticks(3);
        send_word(CMD_LOAD, 32'd731);
        send_ticks(3);

        send_random_words(WORDS_PER_PHASE);

        tx_gap_pct    = 52;
        rx_stall_pct <= 22;
        send_random_words(WORDS_PER_PHASE);

        tx_gap_pct    = 0;
        rx_stall_pct <= 0;
        send_random_words(WORDS_PER_PHASE);
        s_axis_tvalid <= 1'b0;

        // drain, then allow for stray words
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending == 0) begin
            $display("three_digit_seven_segment_scan_tb OK");
        end else begin
            $display("three_digit_seven_segment_scan_tb NOT OK");
        end
        $finish;
    end

endmodule
